>>> sv/rbmgt_pkg.sv
// ----------------------------------------------------------------------------
// RBM Gibbs trainer package
// Shared types, operation and register codes, and default sizes.
// ----------------------------------------------------------------------------
package rbmgt_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_VIS_UNITS       = 8;
  localparam int DEF_HID_UNITS       = 8;
  localparam int DEF_WEIGHT_BITS     = 16;
  localparam int DEF_ACC_BITS        = 32;
  localparam int DEF_SIGMOID_ENTRIES = 256;

  // Register reset values.
  localparam logic [15:0] RATE_RESET  = 16'd4096;
  localparam logic [15:0] COUNT_RESET = 16'd1000;

  // Operation codes; codes above OP_READ are unused.
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_DATA   = 3'd1,
    OP_GIBBS  = 3'd2,
    OP_UPDATE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RATE      = 2'd0,
    CFG_DATA_CNT  = 2'd1,
    CFG_PART_CNT  = 2'd2
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RDWAIT,
    S_SUM_RD, S_SUM_ACC, S_SIG1, S_SIG2, S_SIG_USE,
    S_DA_RD, S_DA_WR, S_END, S_MA_RD, S_MA_WR,
    S_UP_RD, S_UP_LOAD, S_UP_DIVA, S_UP_STB, S_UP_DIVB,
    S_UP_DIFF, S_UP_SCALE, S_UP_MUL, S_UP_DIVE, S_UP_WR,
    S_DONE
  } state_t;

  // Which column or row sum the shared sum loop is working on.
  typedef enum logic [1:0] {
    PH_DATA, PH_GH, PH_GV
  } phase_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         vis_pattern;
    logic [3:0]         vis_index;
    logic [3:0]         hid_index;
    logic signed [15:0] weight_value;
    logic [11:0]        rand_hidden;
    logic [11:0]        rand_visible;
    logic               particle_start;
    logic               particle_end;
  } item_t;

  typedef struct packed {
    logic signed [15:0] read_weight;
    logic               hidden_sample;
    logic               visible_sample;
    logic [15:0]        epoch_count;
  } result_t;

  typedef struct packed {
    logic [15:0] learn_rate_init;
    logic [15:0] data_count;
    logic [15:0] particle_count;
  } cfg_t;

endpackage

>>> sv/rbm_gibbs_trainer_unit.sv
// ----------------------------------------------------------------------------
// RBM Gibbs trainer
// Top level: request and result streams, configuration registers and the
// result register in front of the training sequencer.
// ----------------------------------------------------------------------------
// Every request gives one result. A data sample walks the weight memory column
// by column. A Gibbs step also adds the particle's outer product when the
// particle ends. A weight update uses the bit-serial divider: per entry two
// divisions, plus a third one after the first update. After reset the block
// clears both accumulator memories before it takes its first request;
// configuration writes are taken at any time.
module rbm_gibbs_trainer_unit #(
  parameter int VIS_UNITS       = rbmgt_pkg::DEF_VIS_UNITS,
  parameter int HID_UNITS       = rbmgt_pkg::DEF_HID_UNITS,
  parameter int WEIGHT_BITS     = rbmgt_pkg::DEF_WEIGHT_BITS,
  parameter int ACC_BITS        = rbmgt_pkg::DEF_ACC_BITS,
  parameter int SIGMOID_ENTRIES = rbmgt_pkg::DEF_SIGMOID_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Requests.
  input  logic        s_tvalid,
  output logic        s_tready,
  // vis_pattern[7:0], vis_index[11:8], hid_index[15:12], weight_value[31:16],
  // rand_hidden[43:32], rand_visible[55:44], particle_start[56],
  // particle_end[57], zero fill above.
  input  logic [63:0] s_tdata,
  // operation[2:0]
  input  logic [2:0]  s_tuser,
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_weight[15:0], hidden_sample[16], visible_sample[17],
  // epoch_count[33:18], zero fill above.
  output logic [39:0] m_tdata
);

  import rbmgt_pkg::*;

  cfg_t    cfg;
  item_t   req;
  result_t res;
  logic    res_valid;
  logic    out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learn_rate_init <= RATE_RESET;
      cfg.data_count      <= COUNT_RESET;
      cfg.particle_count  <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RATE:     cfg.learn_rate_init <= cfg_wdata;
        CFG_DATA_CNT: cfg.data_count      <= cfg_wdata;
        CFG_PART_CNT: cfg.particle_count  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the request stream.
  always_comb begin
    req.operation      = s_tuser;
    req.vis_pattern    = s_tdata[7:0];
    req.vis_index      = s_tdata[11:8];
    req.hid_index      = s_tdata[15:12];
    req.weight_value   = s_tdata[31:16];
    req.rand_hidden    = s_tdata[43:32];
    req.rand_visible   = s_tdata[55:44];
    req.particle_start = s_tdata[56];
    req.particle_end   = s_tdata[57];
  end

  assign out_free = !m_tvalid || m_tready;

  rbmgt_core #(
    .VIS_UNITS       (VIS_UNITS),
    .HID_UNITS       (HID_UNITS),
    .WEIGHT_BITS     (WEIGHT_BITS),
    .ACC_BITS        (ACC_BITS),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (s_tvalid),
    .req       (req),
    .req_ready (s_tready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register; the sequencer finishes only when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {6'd0, res.epoch_count, res.visible_sample, res.hidden_sample,
                  res.read_weight};
    end
  end

endmodule

>>> sv/rbmgt_sigmoid.sv
// ----------------------------------------------------------------------------
// RBM sigmoid lookup
// Clamps a Q4.12 sum to [-8, 8), bins it and reads a Q1.12 sigmoid table.
// Two register stages: bin index, then table value.
// ----------------------------------------------------------------------------
module rbmgt_sigmoid #(
  parameter int ENTRIES = 256,
  parameter int SUM_W   = 21
) (
  input  logic                    clk,
  input  logic signed [SUM_W-1:0] sum,
  output logic [12:0]             mu
);

  localparam int XW = $clog2(ENTRIES);
  localparam longint unsigned ONE_Q32 = 64'd1 << 32;

  typedef logic [12:0] tab_t [ENTRIES];

  // Long division by shift and subtract, used only while the table is built.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q, rm;
    q  = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[62:0], n[b]};
      if (rm >= d) begin
        rm   = rm - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k holds the sigmoid of the bin midpoint, built in Q0.32.
  function automatic tab_t build_tab();
    tab_t            t;
    longint unsigned pw [ENTRIES];
    longint unsigned d, term, r, e, den, num;
    int              m;
    d    = udiv(64'd8 << 32, 64'(ENTRIES));
    term = ONE_Q32;
    r    = ONE_Q32;
    for (int k = 1; k <= 12; k++) begin
      term = udiv((term * d) >> 32, 64'(k));
      if ((k & 1) == 1) r = r - term;
      else r = r + term;
    end
    pw[0] = ONE_Q32;
    for (int k = 1; k < ENTRIES; k++) begin
      if (k == 1) pw[k] = r;
      else pw[k] = (pw[k-1] * r + (64'd1 << 31)) >> 32;
    end
    for (int k = 0; k < ENTRIES; k++) begin
      m   = 2 * k + 1 - ENTRIES;
      e   = pw[(m < 0) ? -m : m];
      den = ONE_Q32 + e;
      num = (m >= 0) ? (64'd4096 << 32) : 64'd4096 * e;
      t[k] = 13'(udiv(num + (den >> 1), den));
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB = build_tab();

  logic signed [32:0] sx;
  logic [15:0]        u;
  logic [31:0]        p;
  logic [XW-1:0]      idx;

  // Clamp and offset the sum, then scale to a bin index.
  always_comb begin
    sx = 33'(sum);
    if (sx < -33'sd32768) sx = -33'sd32768;
    if (sx > 33'sd32767) sx = 33'sd32767;
    u = 16'(sx + 33'sd32768);
    p = 32'(u) * 32'(ENTRIES);
  end

  always_ff @(posedge clk) begin
    idx <= p[16 +: XW];
    mu  <= SIG_TAB[idx];
  end

endmodule

>>> sv/rbmgt_divider.sv
// ----------------------------------------------------------------------------
// RBM iterative divider
// Unsigned restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rbmgt_divider #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsor;
  logic [DEN_W:0]   r2;
  logic             ge;

  // Trial subtract of the shifted partial remainder.
  always_comb begin
    r2 = {rem, acc[NUM_W-1]};
    ge = (r2 >= {1'b0, dsor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the numerator register as it empties.
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= num;
      rem  <= '0;
      dsor <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= ge ? DEN_W'(r2 - {1'b0, dsor}) : r2[DEN_W-1:0];
    end
  end

  assign quot = acc;

endmodule

>>> sv/rbmgt_core.sv
// ----------------------------------------------------------------------------
// RBM training sequencer
// Holds the weight and accumulator memories and steps through each operation
// by read-modify-write passes over them.
// ----------------------------------------------------------------------------
module rbmgt_core #(
  parameter int VIS_UNITS       = 8,
  parameter int HID_UNITS       = 8,
  parameter int WEIGHT_BITS     = 16,
  parameter int ACC_BITS        = 32,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  rbmgt_pkg::cfg_t   cfg,
  input  logic              req_valid,
  input  rbmgt_pkg::item_t  req,
  output logic              req_ready,
  input  logic              out_free,
  output logic              res_valid,
  output rbmgt_pkg::result_t res
);

  import rbmgt_pkg::*;

  localparam int IW    = (VIS_UNITS > 1) ? $clog2(VIS_UNITS) : 1;
  localparam int JW    = (HID_UNITS > 1) ? $clog2(HID_UNITS) : 1;
  localparam int AW    = IW + JW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = WEIGHT_BITS + 5;
  localparam int DIV_W = (ACC_BITS + 13 > 41) ? ACC_BITS + 13 : 41;
  localparam int DW    = (ACC_BITS + 14 > 42) ? ACC_BITS + 14 : 42;
  localparam int DMW   = 48;
  localparam longint WMAX = (64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1;
  localparam longint WMIN = -WMAX - 64'sd1;
  localparam logic signed [DW-1:0] LIM = DW'(64'sd1 <<< 40);

  // Saturate a 64-bit value to the weight width.
  function automatic logic [WEIGHT_BITS-1:0] wsat(input logic signed [63:0] v);
    logic signed [63:0] x;
    x = v;
    if (x > WMAX) x = WMAX;
    if (x < WMIN) x = WMIN;
    return WEIGHT_BITS'(x);
  endfunction

  // Saturate a stored weight to the 16-bit result field.
  function automatic logic [15:0] sat16(input logic signed [WEIGHT_BITS-1:0] w);
    logic signed [63:0] x;
    x = 64'(w);
    if (x > 64'sd32767) x = 64'sd32767;
    if (x < -64'sd32768) x = -64'sd32768;
    return 16'(x);
  endfunction

  // Saturating accumulator add.
  function automatic logic [ACC_BITS-1:0] acc_add(input logic [ACC_BITS-1:0] a,
                                                  input logic [12:0] b);
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + (ACC_BITS + 1)'(b);
    return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
  endfunction

  state_t state, state_next;
  phase_t phase;
  item_t  item;

  logic [IW-1:0] ci;
  logic [JW-1:0] cj;
  logic          ci_last, cj_last;
  logic [VIS_UNITS-1:0] fv;
  logic [HID_UNITS-1:0] fh;
  logic [15:0]   epoch;

  logic          vi_ok, hj_ok;
  logic [IW-1:0] vi_a;
  logic [JW-1:0] hj_a;
  logic          pat_bit, sum_bit, sum_last;
  logic [AW-1:0] sum_addr, raddr, waddr;

  // Memories and their ports.
  logic [WEIGHT_BITS-1:0] w_mem [DEPTH];
  logic [ACC_BITS-1:0]    d_mem [DEPTH];
  logic [ACC_BITS-1:0]    m_mem [DEPTH];
  logic                   w_we, d_we, m_we;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
  logic [ACC_BITS-1:0]    d_wdata, d_rdata, m_wdata, m_rdata;

  // Datapath registers.
  logic signed [SW-1:0]          sum;
  logic [12:0]                   mu;
  logic signed [WEIGHT_BITS-1:0] w_reg;
  logic [ACC_BITS-1:0]           model_reg;
  logic [ACC_BITS:0]             a_reg;
  logic [ACC_BITS+12:0]          b_reg;
  logic                          neg;
  logic [40:0]                   mag;
  logic [56:0]                   prod;
  logic [DMW-1:0]                dmag;
  logic signed [15:0]            res_rd;
  logic                          res_hs, res_vs;

  logic signed [DW-1:0]  diff_c;
  logic signed [63:0]    delta, new_w;
  logic [15:0]           n_div, m_div;
  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_num, div_quot;
  logic [15:0]           div_den;

  rbmgt_sigmoid #(.ENTRIES(SIGMOID_ENTRIES), .SUM_W(SW)) u_sig (
    .clk (clk),
    .sum (sum),
    .mu  (mu)
  );

  rbmgt_divider #(.NUM_W(DIV_W), .DEN_W(16)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Decoded item fields and loop conditions.
  always_comb begin
    vi_ok    = (5'(item.vis_index) < 5'(VIS_UNITS));
    hj_ok    = (5'(item.hid_index) < 5'(HID_UNITS));
    vi_a     = item.vis_index[IW-1:0];
    hj_a     = item.hid_index[JW-1:0];
    ci_last  = (ci == IW'(VIS_UNITS - 1));
    cj_last  = (cj == JW'(HID_UNITS - 1));
    pat_bit  = (int'(ci) < 8) && item.vis_pattern[3'(ci)];
    n_div    = (cfg.data_count == 16'd0) ? 16'd1 : cfg.data_count;
    m_div    = (cfg.particle_count == 16'd0) ? 16'd1 : cfg.particle_count;
    case (phase)
      PH_DATA: begin
        sum_addr = {ci, cj};
        sum_bit  = pat_bit;
        sum_last = ci_last;
      end
      PH_GH: begin
        sum_addr = {ci, hj_a};
        sum_bit  = fv[ci];
        sum_last = ci_last;
      end
      PH_GV: begin
        sum_addr = {vi_a, cj};
        sum_bit  = fh[cj];
        sum_last = cj_last;
      end
      default: begin
        sum_addr = {ci, cj};
        sum_bit  = 1'b0;
        sum_last = 1'b1;
      end
    endcase
  end

  // Update arithmetic: clamped difference and the new weight.
  always_comb begin
    diff_c = $signed(DW'(a_reg)) - $signed(DW'(b_reg));
    if (diff_c > LIM) diff_c = LIM;
    if (diff_c < -LIM) diff_c = -LIM;
    delta = $signed(64'(dmag));
    if (neg) delta = -delta;
    new_w = 64'(w_reg) + delta;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (ci_last && cj_last) state_next = S_IDLE;
      S_IDLE:     if (req_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (item.operation)
          OP_WRITE:  state_next = S_DONE;
          OP_READ:   state_next = (vi_ok && hj_ok) ? S_RDWAIT : S_DONE;
          OP_DATA:   state_next = S_SUM_RD;
          OP_GIBBS:  state_next = (vi_ok || hj_ok) ? S_SUM_RD : S_END;
          OP_UPDATE: state_next = S_UP_RD;
          default:   state_next = S_DONE;
        endcase
      end
      S_RDWAIT:   state_next = S_DONE;
      S_SUM_RD:   state_next = S_SUM_ACC;
      S_SUM_ACC:  state_next = sum_last ? S_SIG1 : S_SUM_RD;
      S_SIG1:     state_next = S_SIG2;
      S_SIG2:     state_next = S_SIG_USE;
      S_SIG_USE: begin
        case (phase)
          PH_DATA: state_next = S_DA_RD;
          PH_GH:   state_next = vi_ok ? S_SUM_RD : S_END;
          default: state_next = S_END;
        endcase
      end
      S_DA_RD:    state_next = S_DA_WR;
      S_DA_WR: begin
        if (!ci_last) state_next = S_DA_RD;
        else state_next = cj_last ? S_DONE : S_SUM_RD;
      end
      S_END:      state_next = item.particle_end ? S_MA_RD : S_DONE;
      S_MA_RD:    state_next = S_MA_WR;
      S_MA_WR:    state_next = (ci_last && cj_last) ? S_DONE : S_MA_RD;
      S_UP_RD:    state_next = S_UP_LOAD;
      S_UP_LOAD:  state_next = S_UP_DIVA;
      S_UP_DIVA:  if (div_done) state_next = S_UP_STB;
      S_UP_STB:   state_next = S_UP_DIVB;
      S_UP_DIVB:  if (div_done) state_next = S_UP_DIFF;
      S_UP_DIFF:  state_next = S_UP_SCALE;
      S_UP_SCALE: state_next = (epoch == 16'd0) ? S_UP_MUL : S_UP_DIVE;
      S_UP_MUL:   state_next = S_UP_WR;
      S_UP_DIVE:  if (div_done) state_next = S_UP_WR;
      S_UP_WR:    state_next = (ci_last && cj_last) ? S_DONE : S_UP_RD;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory and divider controls.
  always_comb begin
    w_we      = 1'b0;
    d_we      = 1'b0;
    m_we      = 1'b0;
    w_wdata   = w_reg;
    d_wdata   = '0;
    m_wdata   = '0;
    div_start = 1'b0;
    div_num   = DIV_W'(mag) + DIV_W'(epoch >> 1);
    div_den   = epoch;
    raddr     = {ci, cj};
    waddr     = {ci, cj};
    req_ready = (state == S_IDLE);
    res_valid = (state == S_DONE) && out_free;
    case (state)
      S_CLEAR: begin
        d_we = 1'b1;
        m_we = 1'b1;
      end
      S_DISPATCH: begin
        raddr   = {vi_a, hj_a};
        waddr   = {vi_a, hj_a};
        w_we    = (item.operation == OP_WRITE) && vi_ok && hj_ok;
        w_wdata = wsat(64'(item.weight_value));
      end
      S_SUM_RD: raddr = sum_addr;
      S_DA_WR: begin
        d_we    = pat_bit;
        d_wdata = acc_add(d_rdata, mu);
      end
      S_MA_WR: begin
        m_we    = fv[ci] & fh[cj];
        m_wdata = acc_add(m_rdata, 13'd1);
      end
      S_UP_LOAD: begin
        div_start = 1'b1;
        div_num   = DIV_W'(d_rdata) + DIV_W'(n_div >> 1);
        div_den   = n_div;
      end
      S_UP_STB: begin
        div_start = 1'b1;
        div_num   = (DIV_W'(model_reg) << 12) + DIV_W'(m_div >> 1);
        div_den   = m_div;
      end
      S_UP_SCALE: div_start = (epoch != 16'd0);
      S_UP_WR: begin
        w_we    = 1'b1;
        d_we    = 1'b1;
        m_we    = 1'b1;
        w_wdata = wsat(new_w);
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (w_we) w_mem[waddr] <= w_wdata;
    if (d_we) d_mem[waddr] <= d_wdata;
    if (m_we) m_mem[waddr] <= m_wdata;
    w_rdata <= w_mem[raddr];
    d_rdata <= d_mem[raddr];
    m_rdata <= m_mem[raddr];
  end

  // Control registers: state, loop counters, fantasy particle, epoch.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_DATA;
      ci    <= '0;
      cj    <= '0;
      fv    <= '0;
      fh    <= '0;
      epoch <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR, S_MA_WR, S_UP_WR: begin
          if (ci_last) begin
            ci <= '0;
            if (!cj_last) cj <= cj + 1'b1;
            else cj <= '0;
          end else begin
            ci <= ci + 1'b1;
          end
          if (state == S_UP_WR && ci_last && cj_last && epoch != 16'hFFFF)
            epoch <= epoch + 16'd1;
        end
        S_DISPATCH: begin
          ci <= '0;
          cj <= '0;
          if (item.operation == OP_DATA) phase <= PH_DATA;
          else phase <= hj_ok ? PH_GH : PH_GV;
          if (item.operation == OP_GIBBS && item.particle_start) begin
            fv <= '0;
            fh <= '0;
          end
        end
        S_SUM_ACC: begin
          if (!sum_last) begin
            if (phase == PH_GV) cj <= cj + 1'b1;
            else ci <= ci + 1'b1;
          end
        end
        S_SIG_USE: begin
          case (phase)
            PH_DATA: ci <= '0;
            PH_GH: begin
              fh[hj_a] <= (mu > {1'b0, item.rand_hidden});
              cj       <= '0;
              phase    <= PH_GV;
            end
            default: fv[vi_a] <= (mu > {1'b0, item.rand_visible});
          endcase
        end
        S_DA_WR: begin
          if (ci_last) begin
            ci <= '0;
            if (!cj_last) cj <= cj + 1'b1;
          end else begin
            ci <= ci + 1'b1;
          end
        end
        S_END: begin
          ci <= '0;
          cj <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) item <= req;
    case (state)
      S_DISPATCH: begin
        sum    <= '0;
        res_rd <= '0;
        res_hs <= 1'b0;
        res_vs <= 1'b0;
        if (item.operation == OP_WRITE && vi_ok && hj_ok)
          res_rd <= sat16(wsat(64'(item.weight_value)));
      end
      S_RDWAIT:  res_rd <= sat16(w_rdata);
      S_SUM_ACC: if (sum_bit) sum <= sum + SW'($signed(w_rdata));
      S_SIG_USE: begin
        // A data column keeps its sum so that the sigmoid stays put while
        // the accumulator pass runs; the last write of the column clears it.
        if (phase != PH_DATA) sum <= '0;
        if (phase == PH_GH) res_hs <= (mu > {1'b0, item.rand_hidden});
        if (phase == PH_GV) res_vs <= (mu > {1'b0, item.rand_visible});
      end
      S_DA_WR:   if (ci_last) sum <= '0;
      S_UP_LOAD: begin
        w_reg     <= w_rdata;
        model_reg <= m_rdata;
      end
      S_UP_DIVA: if (div_done) a_reg <= div_quot[ACC_BITS:0];
      S_UP_DIVB: if (div_done) b_reg <= div_quot[ACC_BITS+12:0];
      S_UP_DIFF: begin
        neg <= diff_c[DW-1];
        mag <= diff_c[DW-1] ? 41'(-diff_c) : 41'(diff_c);
      end
      S_UP_SCALE: prod <= 57'(mag) * 57'(cfg.learn_rate_init);
      S_UP_MUL:   dmag <= DMW'((prod + 57'd2048) >> 12);
      S_UP_DIVE:  if (div_done) dmag <= DMW'(div_quot);
      default: ;
    endcase
  end

  assign res.read_weight    = res_rd;
  assign res.hidden_sample  = res_hs;
  assign res.visible_sample = res_vs;
  assign res.epoch_count    = epoch;

endmodule
